[hw/rtl/tensor_address_range_table_macros.svh]
// Assertion macros for the tensor address range table.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef TENSOR_ADDRESS_RANGE_TABLE_MACROS_SVH
`define TENSOR_ADDRESS_RANGE_TABLE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TART_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TART_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tart_pkg.sv]
// Shared types and codes for the tensor address range table.
// No dependencies.
package tart_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_PRE,
        S_WALK
    } t_state;

    localparam logic [1:0] KIND_DIM = 2'd0;
    localparam logic [1:0] KIND_INS = 2'd1;
    localparam logic [1:0] KIND_FWD = 2'd2;
    localparam logic [1:0] KIND_REV = 2'd3;

    localparam logic [1:0] PERR_NONE   = 2'd0;
    localparam logic [1:0] PERR_ZERO   = 2'd1;
    localparam logic [1:0] PERR_STRIDE = 2'd2;
    localparam logic [1:0] PERR_OVF    = 2'd3;

    localparam logic [3:0] STAT_OK        = 4'd0;
    localparam logic [3:0] STAT_STRIDE    = 4'd2;
    localparam logic [3:0] STAT_SIZE_OVF  = 4'd3;
    localparam logic [3:0] STAT_EMPTY     = 4'd4;
    localparam logic [3:0] STAT_ZERO_BASE = 4'd5;
    localparam logic [3:0] STAT_SMALL     = 4'd6;
    localparam logic [3:0] STAT_ADDR_OVF  = 4'd7;
    localparam logic [3:0] STAT_DUP       = 4'd8;
    localparam logic [3:0] STAT_OVERLAP   = 4'd9;
    localparam logic [3:0] STAT_FULL      = 4'd10;
    localparam logic [3:0] STAT_NOT_FOUND = 4'd11;
    localparam logic [3:0] STAT_ELEM_OOR  = 4'd12;
    localparam logic [3:0] STAT_BIT_OOR   = 4'd13;
    localparam logic [3:0] STAT_BYTE_BIT  = 4'd14;

    typedef struct packed {
        logic [7:0]  key;
        logic [63:0] base;
        logic [63:0] elems;
        logic [1:0]  dtype;
    } t_entry;

endpackage

[hw/rtl/tart_mul.sv]
// Sequential 64x64 multiplier built from four 32x32 partial products.
// Depends on nothing; used by the table top level for the shape product.
module tart_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_lo,
    output logic        o_hi_nz
);

    logic [63:0]  r_a, r_b;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;
    logic [2:0]   r_step;
    logic         r_run;
    logic         r_done;
    logic [31:0]  w_x, w_y;
    logic [127:0] w_pp_sh;

    // Select operand halves for this step
    always_comb begin
        case (r_step)
            3'd0:    begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            3'd1:    begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            3'd2:    begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            default: begin w_x = r_a[63:32]; w_y = r_b[63:32]; end
        endcase
    end

    // Align the previous partial product
    always_comb begin
        case (r_step)
            3'd1:    w_pp_sh = {64'b0, r_pp};
            3'd2,
            3'd3:    w_pp_sh = {32'b0, r_pp, 32'b0};
            default: w_pp_sh = {r_pp, 64'b0};
        endcase
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_step == 3'd4);
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= 3'd0;
            end else if (r_run) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd4) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // Multiply and accumulate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= 128'b0;
        end else if (r_run) begin
            r_pp <= w_x * w_y;
            if (r_step != 3'd0) begin
                r_acc <= r_acc + w_pp_sh;
            end
        end
    end

    assign o_done  = r_done;
    assign o_lo    = r_acc[63:0];
    assign o_hi_nz = (r_acc[127:64] != 64'b0);

endmodule

[hw/rtl/tensor_address_range_table.sv]
// Tensor address range table: dimension items run through the multiplier;
// inserts and lookups walk the stored entries in turn, set by the single read
// port of the entry memory.
// One item at a time; o_busy is high from accept until the result strobe.
// The result sits on the outputs for one cycle with o_valid; no stall.
// Synchronous reset empties the table and the pending shape at once.
module tensor_address_range_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_tensor_id,
    input  logic [63:0] i_dim_size,
    input  logic [63:0] i_dim_stride,
    input  logic        i_stride_given,
    input  logic [1:0]  i_dtype,
    input  logic [63:0] i_address,
    input  logic [63:0] i_alloc_size,
    input  logic [63:0] i_element_index,
    input  logic [7:0]  i_element_bit,
    input  logic [7:0]  i_byte_bit,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [7:0]  o_found_id,
    output logic [63:0] o_found_element,
    output logic [4:0]  o_found_element_bit,
    output logic [63:0] o_byte_offset,
    output logic [2:0]  o_bit_position,
    output logic [7:0]  o_bit_mask,
    output logic [63:0] o_byte_address
);

    `include "tensor_address_range_table_macros.svh"

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(tart_pkg::t_entry);

    tart_pkg::t_state r_state, n_state;

    // Captured item
    logic [1:0]  r_kind;
    logic [7:0]  r_key;
    logic [63:0] r_size, r_stride, r_addr, r_alloc, r_eidx;
    logic        r_sgiven;
    logic [1:0]  r_dtype;
    logic [7:0]  r_ebit, r_bbit;

    // Pending shape
    logic [63:0] r_prod;
    logic        r_seen, r_given, r_miss;
    logic [1:0]  r_err;

    // Table control
    logic [FW-1:0] r_fill;
    logic [IW-1:0] r_idx;
    logic [63:0]   r_end;

    // Entry memory
    logic [EW-1:0]    r_mem [TABLE_DEPTH];
    tart_pkg::t_entry r_rdata;
    logic [IW-1:0]    w_rd_addr;

    // Result
    logic        r_valid;
    logic [3:0]  r_status;
    logic [7:0]  r_fid;
    logic [63:0] r_felem, r_boff, r_baddr;
    logic [4:0]  r_fbit;
    logic [2:0]  r_bpos;
    logic [7:0]  r_bmask;

    logic        w_accept;
    logic        w_mul_start, w_mul_done, w_mul_hi_nz;
    logic [63:0] w_mul_lo;
    logic        w_fin, w_to_walk, w_write;
    logic [3:0]  w_status;
    logic [7:0]  w_fid;
    logic [63:0] w_felem, w_boff, w_baddr;
    logic [4:0]  w_fbit;
    logic [2:0]  w_bpos;
    logic [7:0]  w_bmask;
    logic        w_last, w_full;
    logic [63:0] w_req, w_ebytes, w_eend, w_off, w_foff;
    logic [64:0] w_sum;
    logic [1:0]  w_nerr;

    assign w_accept    = i_start && (r_state == tart_pkg::S_IDLE);
    assign w_mul_start = w_accept && (i_kind == tart_pkg::KIND_DIM);
    assign w_last      = ((FW'(r_idx) + FW'(1)) == r_fill);
    assign w_full      = (r_fill >= FW'(TABLE_DEPTH));
    assign w_rd_addr   = (r_state == tart_pkg::S_WALK) ? (r_idx + IW'(1)) : IW'(0);

    tart_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_prod),
        .i_b     (i_dim_size),
        .o_done  (w_mul_done),
        .o_lo    (w_mul_lo),
        .o_hi_nz (w_mul_hi_nz)
    );

    // Insert range terms from the pending shape
    assign w_req = r_dtype[1] ? {r_prod[61:0], 2'b0} : r_prod;
    assign w_sum = {1'b0, r_addr} + {1'b0, w_req};

    // Terms of the stored entry under walk
    assign w_ebytes = r_rdata.dtype[1] ? {r_rdata.elems[61:0], 2'b0} : r_rdata.elems;
    assign w_eend   = r_rdata.base + w_ebytes;
    assign w_off    = r_addr - r_rdata.base;
    assign w_foff   = r_rdata.dtype[1] ? {r_eidx[61:0], r_ebit[4:3]} : r_eidx;

    // Latch the first shape error of a dimension word
    always_comb begin
        w_nerr = r_err;
        if (r_sgiven && (r_stride != r_prod) && (w_nerr == tart_pkg::PERR_NONE)) begin
            w_nerr = tart_pkg::PERR_STRIDE;
        end
        if ((r_size == 64'b0) && (w_nerr == tart_pkg::PERR_NONE)) begin
            w_nerr = tart_pkg::PERR_ZERO;
        end
        if (w_mul_hi_nz && (w_nerr == tart_pkg::PERR_NONE)) begin
            w_nerr = tart_pkg::PERR_OVF;
        end
    end

    // Evaluate the current step
    always_comb begin
        w_fin     = 1'b0;
        w_to_walk = 1'b0;
        w_write   = 1'b0;
        w_status  = tart_pkg::STAT_OK;
        w_fid     = 8'b0;
        w_felem   = 64'b0;
        w_fbit    = 5'b0;
        w_boff    = 64'b0;
        w_bpos    = 3'b0;
        w_bmask   = 8'b0;
        w_baddr   = 64'b0;
        case (r_state)
            tart_pkg::S_MUL: begin
                w_fin = w_mul_done;
            end
            tart_pkg::S_PRE: begin
                case (r_kind)
                    tart_pkg::KIND_INS: begin
                        w_fin = 1'b1;
                        if (r_addr == 64'b0) begin
                            w_status = tart_pkg::STAT_ZERO_BASE;
                        end else if (r_given && r_miss) begin
                            w_status = tart_pkg::STAT_STRIDE;
                        end else if (r_err != tart_pkg::PERR_NONE) begin
                            w_status = {2'b0, r_err};
                        end else if (!r_seen) begin
                            w_status = tart_pkg::STAT_EMPTY;
                        end else if (r_dtype[1] && (r_prod[63:62] != 2'b0)) begin
                            w_status = tart_pkg::STAT_SIZE_OVF;
                        end else if (r_alloc < w_req) begin
                            w_status = tart_pkg::STAT_SMALL;
                        end else if (w_sum[64]) begin
                            w_status = tart_pkg::STAT_ADDR_OVF;
                        end else if (r_fill != FW'(0)) begin
                            w_fin     = 1'b0;
                            w_to_walk = 1'b1;
                        end else if (w_full) begin
                            w_status = tart_pkg::STAT_FULL;
                        end else begin
                            w_write = 1'b1;
                        end
                    end
                    tart_pkg::KIND_REV: begin
                        if (r_bbit[7:3] != 5'b0) begin
                            w_fin    = 1'b1;
                            w_status = tart_pkg::STAT_BYTE_BIT;
                        end else if (r_fill == FW'(0)) begin
                            w_fin    = 1'b1;
                            w_status = tart_pkg::STAT_NOT_FOUND;
                        end else begin
                            w_to_walk = 1'b1;
                        end
                    end
                    default: begin
                        if (r_fill == FW'(0)) begin
                            w_fin    = 1'b1;
                            w_status = tart_pkg::STAT_NOT_FOUND;
                        end else begin
                            w_to_walk = 1'b1;
                        end
                    end
                endcase
            end
            tart_pkg::S_WALK: begin
                case (r_kind)
                    tart_pkg::KIND_INS: begin
                        if (r_rdata.key == r_key) begin
                            w_fin    = 1'b1;
                            w_status = tart_pkg::STAT_DUP;
                        end else if ((r_addr < w_eend) && (r_rdata.base < r_end)) begin
                            w_fin    = 1'b1;
                            w_status = tart_pkg::STAT_OVERLAP;
                        end else if (w_last) begin
                            w_fin = 1'b1;
                            if (w_full) begin
                                w_status = tart_pkg::STAT_FULL;
                            end else begin
                                w_write = 1'b1;
                            end
                        end
                    end
                    tart_pkg::KIND_FWD: begin
                        if (r_rdata.key == r_key) begin
                            w_fin = 1'b1;
                            if (r_eidx >= r_rdata.elems) begin
                                w_status = tart_pkg::STAT_ELEM_OOR;
                            end else if (r_rdata.dtype[1] ? (r_ebit[7:5] != 3'b0)
                                                           : (r_ebit[7:3] != 5'b0)) begin
                                w_status = tart_pkg::STAT_BIT_OOR;
                            end else begin
                                w_fid   = r_key;
                                w_felem = r_eidx;
                                w_fbit  = r_ebit[4:0];
                                w_boff  = w_foff;
                                w_bpos  = r_ebit[2:0];
                                w_bmask = 8'b1 << r_ebit[2:0];
                                w_baddr = r_rdata.base + w_foff;
                            end
                        end else if (w_last) begin
                            w_fin    = 1'b1;
                            w_status = tart_pkg::STAT_NOT_FOUND;
                        end
                    end
                    default: begin
                        if ((r_addr >= r_rdata.base) && (w_off < w_ebytes)) begin
                            w_fin   = 1'b1;
                            w_fid   = r_rdata.key;
                            w_felem = r_rdata.dtype[1] ? {2'b0, w_off[63:2]} : w_off;
                            w_fbit  = r_rdata.dtype[1] ? {w_off[1:0], r_bbit[2:0]}
                                                       : {2'b0, r_bbit[2:0]};
                            w_boff  = w_off;
                            w_bpos  = r_bbit[2:0];
                            w_bmask = 8'b1 << r_bbit[2:0];
                            w_baddr = r_addr;
                        end else if (w_last) begin
                            w_fin    = 1'b1;
                            w_status = tart_pkg::STAT_NOT_FOUND;
                        end
                    end
                endcase
            end
            default: begin
                w_fin = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tart_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_kind == tart_pkg::KIND_DIM) ? tart_pkg::S_MUL
                                                             : tart_pkg::S_PRE;
                end
            end
            tart_pkg::S_MUL: begin
                if (w_fin) n_state = tart_pkg::S_IDLE;
            end
            tart_pkg::S_PRE: begin
                if (w_fin) begin
                    n_state = tart_pkg::S_IDLE;
                end else if (w_to_walk) begin
                    n_state = tart_pkg::S_WALK;
                end
            end
            tart_pkg::S_WALK: begin
                if (w_fin) n_state = tart_pkg::S_IDLE;
            end
            default: n_state = tart_pkg::S_IDLE;
        endcase
    end

    // Control registers and pending shape
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tart_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_fill  <= '0;
            r_prod  <= 64'd1;
            r_seen  <= 1'b0;
            r_given <= 1'b0;
            r_miss  <= 1'b0;
            r_err   <= tart_pkg::PERR_NONE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= w_fin;
            if (r_state == tart_pkg::S_WALK) begin
                r_idx <= r_idx + IW'(1);
            end else begin
                r_idx <= '0;
            end
            if (w_fin && (r_state == tart_pkg::S_MUL)) begin
                r_seen  <= 1'b1;
                r_given <= r_given | r_sgiven;
                r_miss  <= r_miss | !r_sgiven;
                r_err   <= w_nerr;
                r_prod  <= w_mul_hi_nz ? 64'b0 : w_mul_lo;
            end
            if (w_fin && (r_kind == tart_pkg::KIND_INS) && (r_state != tart_pkg::S_MUL)) begin
                r_prod  <= 64'd1;
                r_seen  <= 1'b0;
                r_given <= 1'b0;
                r_miss  <= 1'b0;
                r_err   <= tart_pkg::PERR_NONE;
            end
            if (w_write) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    // Capture the item word and the insert end
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_kind;
            r_key    <= i_tensor_id;
            r_size   <= i_dim_size;
            r_stride <= i_dim_stride;
            r_sgiven <= i_stride_given;
            r_dtype  <= i_dtype;
            r_addr   <= i_address;
            r_alloc  <= i_alloc_size;
            r_eidx   <= i_element_index;
            r_ebit   <= i_element_bit;
            r_bbit   <= i_byte_bit;
        end
        if (r_state == tart_pkg::S_PRE) begin
            r_end <= w_sum[63:0];
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_fill[IW-1:0]] <= {r_key, r_addr, r_prod, r_dtype};
        end
        r_rdata <= tart_pkg::t_entry'(r_mem[w_rd_addr]);
    end

    // Hold the result word
    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_status <= w_status;
            r_fid    <= w_fid;
            r_felem  <= w_felem;
            r_fbit   <= w_fbit;
            r_boff   <= w_boff;
            r_bpos   <= w_bpos;
            r_bmask  <= w_bmask;
            r_baddr  <= w_baddr;
        end
    end

    assign o_busy              = (r_state != tart_pkg::S_IDLE);
    assign o_valid             = r_valid;
    assign o_status            = r_status;
    assign o_found_id          = r_fid;
    assign o_found_element     = r_felem;
    assign o_found_element_bit = r_fbit;
    assign o_byte_offset       = r_boff;
    assign o_bit_position      = r_bpos;
    assign o_bit_mask          = r_bmask;
    assign o_byte_address      = r_baddr;

    `TART_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobe longer than one cycle")
    `TART_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FW'(TABLE_DEPTH), "fill count past depth")
    `TART_ASSERT_SAME(a_write_room, w_write, !w_full, "entry write into a full table")
    `TART_ASSERT_SAME(a_mul_done_state, w_mul_done, r_state == tart_pkg::S_MUL, "multiplier done outside dimension step")

endmodule

[sim/tb_tensor_address_range_table.sv]
// Self-checking testbench for tensor_address_range_table: a directed table, then random words.
// Depends on tart_pkg and the tensor_address_range_table RTL.
`timescale 1ns / 100ps

module tb_tensor_address_range_table;

    localparam int DEPTH = 16;
    localparam logic [3:0] STAT_ZERO_DIM = 4'd1;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [63:0] dim_size;
        logic [63:0] dim_stride;
        logic        stride_given;
        logic [1:0]  dtype;
        logic [63:0] address;
        logic [63:0] alloc_size;
        logic [63:0] elem_idx;
        logic [7:0]  elem_bit;
        logic [7:0]  byte_bit;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  id;
        logic [63:0] element;
        logic [4:0]  elem_bit;
        logic [63:0] offset;
        logic [2:0]  bit_pos;
        logic [7:0]  mask;
        logic [63:0] byte_addr;
    } t_res;

    typedef struct {
        t_cmd       cmd;
        bit         typed;
        logic [3:0] status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_kind;
    logic [7:0]  i_tensor_id;
    logic [63:0] i_dim_size;
    logic [63:0] i_dim_stride;
    logic        i_stride_given;
    logic [1:0]  i_dtype;
    logic [63:0] i_address;
    logic [63:0] i_alloc_size;
    logic [63:0] i_element_index;
    logic [7:0]  i_element_bit;
    logic [7:0]  i_byte_bit;
    logic        o_valid;
    logic [3:0]  o_status;
    logic [7:0]  o_found_id;
    logic [63:0] o_found_element;
    logic [4:0]  o_found_element_bit;
    logic [63:0] o_byte_offset;
    logic [2:0]  o_bit_position;
    logic [7:0]  o_bit_mask;
    logic [63:0] o_byte_address;

    tensor_address_range_table #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // Predictor copy of the table and the pending shape
    int unsigned tbl_fill;
    logic [7:0]  tbl_key [DEPTH];
    logic [63:0] tbl_base [DEPTH];
    logic [63:0] tbl_elems [DEPTH];
    logic [1:0]  tbl_type [DEPTH];
    logic [63:0] shape_count;
    bit          shape_seen, shape_given, shape_missing;
    logic [1:0]  shape_err;

    t_res expected_results[$];
    int   errors;
    int   mismatches;
    int   idle_pct;
    int   issued;

    function automatic logic [63:0] elem_size(logic [1:0] t);
        return t[1] ? 64'd4 : 64'd1;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic void latch_shape_err(logic [1:0] code);
        if (shape_err == tart_pkg::PERR_NONE) shape_err = code;
    endfunction

    function automatic logic [3:0] table_insert(t_cmd c);
        logic [127:0] bytes;
        logic [64:0]  span_end;
        logic [63:0]  req, eend;
        if (c.address == 64'd0) return tart_pkg::STAT_ZERO_BASE;
        if (shape_given && shape_missing) return tart_pkg::STAT_STRIDE;
        if (shape_err != tart_pkg::PERR_NONE) return {2'b00, shape_err};
        if (!shape_seen) return tart_pkg::STAT_EMPTY;
        bytes = shape_count * elem_size(c.dtype);
        if (bytes[127:64] != 64'd0) return tart_pkg::STAT_SIZE_OVF;
        req = bytes[63:0];
        if (c.alloc_size < req) return tart_pkg::STAT_SMALL;
        span_end = {1'b0, c.address} + {1'b0, req};
        if (span_end[64]) return tart_pkg::STAT_ADDR_OVF;
        for (int i = 0; i < tbl_fill; i++) begin
            eend = tbl_base[i] + tbl_elems[i] * elem_size(tbl_type[i]);
            if (tbl_key[i] == c.id) return tart_pkg::STAT_DUP;
            if (c.address < eend && tbl_base[i] < span_end[63:0]) return tart_pkg::STAT_OVERLAP;
        end
        if (tbl_fill >= DEPTH) return tart_pkg::STAT_FULL;
        tbl_key[tbl_fill] = c.id;
        tbl_base[tbl_fill] = c.address;
        tbl_elems[tbl_fill] = shape_count;
        tbl_type[tbl_fill] = c.dtype;
        tbl_fill++;
        return tart_pkg::STAT_OK;
    endfunction

    // Work out the result of one word and advance the predictor state
    function automatic t_res predict_range_result(t_cmd c);
        t_res r;
        logic [127:0] prod;
        logic [63:0] sz, off;
        r = '0;
        case (c.kind)
            tart_pkg::KIND_DIM: begin
                shape_seen = 1'b1;
                if (c.stride_given) begin
                    shape_given = 1'b1;
                    if (c.dim_stride != shape_count) latch_shape_err(tart_pkg::PERR_STRIDE);
                end else begin
                    shape_missing = 1'b1;
                end
                if (c.dim_size == 64'd0) latch_shape_err(tart_pkg::PERR_ZERO);
                prod = shape_count * c.dim_size;
                if (shape_count != 64'd0 && prod[127:64] != 64'd0) begin
                    latch_shape_err(tart_pkg::PERR_OVF);
                    shape_count = 64'd0;
                end else begin
                    shape_count = prod[63:0];
                end
            end
            tart_pkg::KIND_INS: begin
                r.status = table_insert(c);
                shape_count = 64'd1;
                {shape_seen, shape_given, shape_missing} = '0;
                shape_err = tart_pkg::PERR_NONE;
            end
            tart_pkg::KIND_FWD: begin
                r.status = tart_pkg::STAT_NOT_FOUND;
                for (int i = 0; i < tbl_fill; i++) begin
                    if (tbl_key[i] == c.id) begin
                        sz = elem_size(tbl_type[i]);
                        if (c.elem_idx >= tbl_elems[i]) r.status = tart_pkg::STAT_ELEM_OOR;
                        else if (c.elem_bit >= sz * 8) r.status = tart_pkg::STAT_BIT_OOR;
                        else begin
                            off = c.elem_idx * sz + 64'(c.elem_bit >> 3);
                            r = '{tart_pkg::STAT_OK, c.id, c.elem_idx, c.elem_bit[4:0], off,
                                  c.elem_bit[2:0], 8'd1 << c.elem_bit[2:0],
                                  tbl_base[i] + off};
                        end
                        break;
                    end
                end
            end
            default: begin
                if (c.byte_bit >= 8'd8) r.status = tart_pkg::STAT_BYTE_BIT;
                else begin
                    r.status = tart_pkg::STAT_NOT_FOUND;
                    for (int i = 0; i < tbl_fill; i++) begin
                        sz = elem_size(tbl_type[i]);
                        if (c.address < tbl_base[i]) continue;
                        off = c.address - tbl_base[i];
                        if (off >= tbl_elems[i] * sz) continue;
                        r = '{tart_pkg::STAT_OK, tbl_key[i], off / sz,
                              5'((off % sz) * 8 + c.byte_bit), off, c.byte_bit[2:0],
                              8'd1 << c.byte_bit[2:0], c.address};
                        break;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Present one word, hold it until accepted, then queue its expectation
    task automatic issue(t_cmd c, bit typed = 1'b0,
                         logic [3:0] typed_status = tart_pkg::STAT_OK);
        t_res r;
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_kind <= c.kind;
        i_tensor_id <= c.id;
        i_dim_size <= c.dim_size;
        i_dim_stride <= c.dim_stride;
        i_stride_given <= c.stride_given;
        i_dtype <= c.dtype;
        i_address <= c.address;
        i_alloc_size <= c.alloc_size;
        i_element_index <= c.elem_idx;
        i_element_bit <= c.elem_bit;
        i_byte_bit <= c.byte_bit;
        i_start <= 1'b1;
        do @(posedge i_clk); while (!(i_start && !o_busy));
        r = predict_range_result(c);
        if (typed) begin
            r = '0;
            r.status = typed_status;
        end
        expected_results = {expected_results, r};
        issued++;
    endtask

    // Hold off the sender until every expected word has come back
    task automatic drain();
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_cmd dim_word(logic [63:0] size, bit given, logic [63:0] stride);
        t_cmd c = '0;
        c.kind = tart_pkg::KIND_DIM;
        c.dim_size = size;
        c.stride_given = given;
        c.dim_stride = stride;
        return c;
    endfunction

    function automatic t_cmd ins_word(logic [7:0] id, logic [1:0] t, logic [63:0] base,
                                      logic [63:0] alloc);
        t_cmd c = '0;
        c.kind = tart_pkg::KIND_INS;
        c.id = id;
        c.dtype = t;
        c.address = base;
        c.alloc_size = alloc;
        return c;
    endfunction

    function automatic t_cmd fwd_word(logic [7:0] id, logic [63:0] idx, logic [7:0] b);
        t_cmd c = '0;
        c.kind = tart_pkg::KIND_FWD;
        c.id = id;
        c.elem_idx = idx;
        c.elem_bit = b;
        return c;
    endfunction

    function automatic t_cmd rev_word(logic [63:0] a, logic [7:0] b);
        t_cmd c = '0;
        c.kind = tart_pkg::KIND_REV;
        c.address = a;
        c.byte_bit = b;
        return c;
    endfunction

    // Random shape followed by an insert; mostly well formed
    task automatic random_insert();
        int ndim;
        bit strided, broken;
        logic [63:0] count, sz, base;
        logic [7:0] id;
        logic [1:0] t;
        ndim = int'($urandom_range(1, 3));
        strided = 1'($urandom_range(1));
        broken = ($urandom_range(9) == 0);
        count = 64'd1;
        for (int d = 0; d < ndim; d++) begin
            sz = 64'($urandom_range(1, 24));
            if (broken && d == ndim - 1) begin
                case ($urandom_range(2))
                    0: issue(dim_word(64'd0, strided, count));
                    1: issue(dim_word(rnd64(), !strided, rnd64()));
                    default: issue(dim_word(sz, 1'b1, count + 64'd1));
                endcase
            end else begin
                issue(dim_word(sz, strided, strided ? count : rnd64()));
            end
            count = count * sz;
        end
        t = 2'($urandom_range(3));
        id = 8'($urandom_range(255));
        if (tbl_fill != 0 && $urandom_range(7) == 0)
            id = tbl_key[$urandom_range(tbl_fill - 1)];
        base = ($urandom_range(9) == 0) ? rnd64() : {32'd0, $urandom_range(1, 1 << 14)};
        issue(ins_word(id, t, base, ($urandom_range(9) == 0) ? rnd64()
                                    : count * elem_size(t) + 64'($urandom_range(3))));
    endtask

    task automatic random_lookup();
        int i;
        logic [63:0] span;
        logic [63:0] bit_span;
        if (tbl_fill == 0 || $urandom_range(7) == 0) begin
            if ($urandom_range(1)) issue(fwd_word(8'($urandom), rnd64(), 8'($urandom)));
            else issue(rev_word(rnd64(), 8'($urandom)));
            return;
        end
        i = int'($urandom_range(tbl_fill - 1));
        span = tbl_elems[i] * elem_size(tbl_type[i]);
        bit_span = 64'd8 * elem_size(tbl_type[i]);
        if ($urandom_range(1))
            issue(fwd_word(tbl_key[i], 64'($urandom_range(tbl_elems[i][31:0])),
                           8'($urandom_range(bit_span[31:0]))));
        else
            issue(rev_word(tbl_base[i] + 64'($urandom_range(span[31:0])),
                           8'($urandom_range(8))));
    endtask

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_status, o_found_id, o_found_element, o_found_element_bit,
                    o_byte_offset, o_bit_position, o_bit_mask, o_byte_address};
            if (expected_results.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result word %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        int phase_end;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_kind <= tart_pkg::KIND_DIM;
        i_tensor_id <= '0;
        i_dim_size <= '0;
        i_dim_stride <= '0;
        i_stride_given <= 1'b0;
        i_dtype <= '0;
        i_address <= '0;
        i_alloc_size <= '0;
        i_element_index <= '0;
        i_element_bit <= '0;
        i_byte_bit <= '0;
        errors = 0;
        mismatches = 0;
        idle_pct = 0;
        issued = 0;
        tbl_fill = 0;
        shape_count = 64'd1;
        {shape_seen, shape_given, shape_missing} = '0;
        shape_err = tart_pkg::PERR_NONE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: empty table, each shape error, each insert error but a full table, lookups
        rows = '{
            '{fwd_word(8'd255, MAX64, 8'd255), 1'b1, tart_pkg::STAT_NOT_FOUND},
            '{rev_word(MAX64, 8'd255), 1'b1, tart_pkg::STAT_BYTE_BIT},
            '{rev_word(64'h1000, 8'd7), 1'b1, tart_pkg::STAT_NOT_FOUND},
            '{ins_word(8'd1, 2'd0, 64'h10, MAX64), 1'b1, tart_pkg::STAT_EMPTY},
            '{dim_word(64'd4, 1'b1, 64'd1), 1'b1, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd0, 64'd0, MAX64), 1'b1, tart_pkg::STAT_ZERO_BASE},
            '{dim_word(64'd0, 1'b0, 64'd0), 1'b1, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd0, 64'h10, MAX64), 1'b1, STAT_ZERO_DIM},
            '{dim_word(64'd4, 1'b1, 64'd1), 1'b0, tart_pkg::STAT_OK},
            '{dim_word(64'd3, 1'b1, 64'd5), 1'b0, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd0, 64'h10, MAX64), 1'b1, tart_pkg::STAT_STRIDE},
            '{dim_word(64'd4, 1'b1, 64'd1), 1'b0, tart_pkg::STAT_OK},
            '{dim_word(64'd3, 1'b0, MAX64), 1'b0, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd0, 64'h10, MAX64), 1'b1, tart_pkg::STAT_STRIDE},
            '{dim_word(MAX64, 1'b0, 64'd0), 1'b0, tart_pkg::STAT_OK},
            '{dim_word(64'd2, 1'b0, 64'd0), 1'b0, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd0, 64'h10, MAX64), 1'b1, tart_pkg::STAT_SIZE_OVF},
            '{dim_word(64'h4000_0000_0000_0000, 1'b0, 64'd0), 1'b0, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd3, 64'h10, MAX64), 1'b1, tart_pkg::STAT_SIZE_OVF},
            '{dim_word(64'd16, 1'b1, 64'd1), 1'b0, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd2, 64'h1000, 64'd63), 1'b1, tart_pkg::STAT_SMALL},
            '{dim_word(64'd16, 1'b0, 64'd0), 1'b0, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd2, MAX64 - 64'd1, MAX64), 1'b1, tart_pkg::STAT_ADDR_OVF},
            '{dim_word(64'd16, 1'b0, 64'd0), 1'b0, tart_pkg::STAT_OK},
            '{ins_word(8'd1, 2'd2, 64'h1000, 64'd64), 1'b0, tart_pkg::STAT_OK}
        };
        foreach (rows[k]) issue(rows[k].cmd, rows[k].typed, rows[k].status);
        issue(dim_word(64'd16, 1'b0, 64'd0));
        issue(ins_word(8'd1, 2'd0, 64'h2000, 64'd16));
        issue(dim_word(64'd16, 1'b0, 64'd0));
        issue(ins_word(8'd2, 2'd1, 64'h1004, 64'd16));
        issue(fwd_word(8'd1, 64'd15, 8'd31));
        issue(fwd_word(8'd1, 64'd16, 8'd0));
        issue(fwd_word(8'd1, 64'd0, 8'd32));
        issue(rev_word(64'h1003, 8'd7));
        issue(rev_word(64'h0FFF, 8'd0));
        drain();

        // Random phases: sender idles rarely, often, then never
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 12 : (phase == 1) ? 77 : 0;
            phase_end = issued + 605;
            while (issued < phase_end) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: random_insert();
                    4: issue(dim_word(rnd64(), 1'($urandom_range(1)), rnd64()));
                    5: issue(ins_word(8'($urandom), 2'($urandom), rnd64(), rnd64()));
                    default: random_lookup();
                endcase
            end
            drain();
        end

        // Let any straggler word appear before judging
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
